// ===== hdl/elew_pkg.sv =====
// Shared types, codes and helper functions for the EPT leaf entry walker.
package elew_pkg;

	localparam int ADDR_W    = 52;
	localparam int GA_W      = 48;
	localparam int DATA_W    = 64;
	localparam int PABITS_W  = 6;
	localparam int IDX_W     = 9;
	localparam int PHYS_MAX  = 40;
	localparam int PAGE_SH   = 12;
	localparam int CFG_IDX_W = 2;

	localparam int SHIFT_L4 = 39;
	localparam int SHIFT_L3 = 30;
	localparam int SHIFT_L2 = 21;
	localparam int SHIFT_L1 = 12;

	localparam int PRESENT_POS = 0;
	localparam int LARGE_POS   = 7;

	localparam logic [PABITS_W-1:0] PABITS_RST = 6'd48;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [GA_W-1:0]   gaddr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOT   = 2'd0,
		CFG_PABITS = 2'd1,
		CFG_ENC    = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_LOOKUP   = 1'b0,
		OP_RESPONSE = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_READ   = 1'b0,
		KIND_RESULT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		OUT_LEAF_4K   = 3'd0,
		OUT_LARGE_2M  = 3'd1,
		OUT_ABSENT_L4 = 3'd2,
		OUT_ABSENT_L3 = 3'd3,
		OUT_HUGE_1G   = 3'd4,
		OUT_ABSENT_L2 = 3'd5
	} outcome_t;

	// walk level: which entry the engine waits for
	typedef enum logic [1:0] {
		LVL_IDLE = 2'd0,
		LVL_L4   = 2'd1,
		LVL_L3   = 2'd2,
		LVL_L2   = 2'd3
	} level_t;

	typedef struct packed {
		logic     emit;
		kind_t    kind;
		addr_t    address;
		outcome_t outcome;
		level_t   next_level;
		logic     save_ga;
		logic     load_last;
	} step_t;

	// bits 12 upward, as many as the physical width says, capped at bit 51
	function automatic addr_t phys_mask(logic [PABITS_W-1:0] bits);
		logic [PABITS_W-1:0] b;
		addr_t m;
		b = (bits > PABITS_W'(PHYS_MAX)) ? PABITS_W'(PHYS_MAX) : bits;
		m = '0;
		for (int j = 0; j < PHYS_MAX; j++)
			m[j + PAGE_SH] = (PABITS_W'(j) < b);
		return m;
	endfunction

	function automatic addr_t level_offset(gaddr_t ga, int shift);
		gaddr_t sh;
		sh = ga >> shift;
		return addr_t'({sh[IDX_W-1:0], 3'b000});
	endfunction

endpackage

// ===== hdl/elew_step.sv =====
// Combinational walk step: next level, read request or final result for one item.
module elew_step (
	input  logic                    opcode,
	input  elew_pkg::gaddr_t        guest_address,
	input  logic [elew_pkg::DATA_W-1:0] read_data,
	input  elew_pkg::level_t        level,
	input  elew_pkg::gaddr_t        saved_ga,
	input  elew_pkg::addr_t         last_addr,
	input  elew_pkg::addr_t         root_addr,
	input  logic [elew_pkg::PABITS_W-1:0] pa_bits,
	input  elew_pkg::addr_t         enc_mask,
	output elew_pkg::step_t         step
);
	import elew_pkg::*;

	addr_t  mask;
	addr_t  base_root;
	addr_t  base_data;
	gaddr_t ga;
	logic   present;
	logic   large_pg;

	assign mask      = phys_mask(pa_bits);
	assign base_root = root_addr & mask & ~enc_mask;
	assign base_data = read_data[ADDR_W-1:0] & mask & ~enc_mask;
	assign ga        = (opcode == OP_LOOKUP) ? guest_address : saved_ga;
	assign present   = read_data[PRESENT_POS];
	assign large_pg  = read_data[LARGE_POS];

	always_comb begin
		step            = '0;
		step.kind       = KIND_READ;
		step.outcome    = OUT_LEAF_4K;
		step.next_level = level;
		if (opcode == OP_LOOKUP) begin
			step.emit       = 1'b1;
			step.address    = base_root | level_offset(ga, SHIFT_L4);
			step.next_level = LVL_L4;
			step.save_ga    = 1'b1;
			step.load_last  = 1'b1;
		end else begin
			case (level)
				LVL_L4: begin
					step.emit = 1'b1;
					if (!present) begin
						step.kind       = KIND_RESULT;
						step.outcome    = OUT_ABSENT_L4;
						step.next_level = LVL_IDLE;
					end else begin
						step.address    = base_data | level_offset(ga, SHIFT_L3);
						step.next_level = LVL_L3;
						step.load_last  = 1'b1;
					end
				end
				LVL_L3: begin
					step.emit = 1'b1;
					if (!present || large_pg) begin
						step.kind       = KIND_RESULT;
						step.outcome    = present ? OUT_HUGE_1G : OUT_ABSENT_L3;
						step.next_level = LVL_IDLE;
					end else begin
						step.address    = base_data | level_offset(ga, SHIFT_L2);
						step.next_level = LVL_L2;
						step.load_last  = 1'b1;
					end
				end
				LVL_L2: begin
					step.emit       = 1'b1;
					step.kind       = KIND_RESULT;
					step.next_level = LVL_IDLE;
					if (!present)
						step.outcome = OUT_ABSENT_L2;
					else if (large_pg) begin
						step.outcome = OUT_LARGE_2M;
						step.address = last_addr;
					end else begin
						// 4K leaf address is reported, never read
						step.outcome = OUT_LEAF_4K;
						step.address = base_data | level_offset(ga, SHIFT_L1);
					end
				end
				default: begin
					// response with no walk in flight is dropped
					step.emit = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/ept_leaf_entry_walker_core.sv =====
// Top level of the EPT leaf entry walker: input stage, walk state and result register.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid in_ready opcode guest_address read_data | item in
//  out     | out_valid out_ready kind address outcome         | item out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data           | write in
//
// One item per cycle unless the result stalls: an item waits in the input register,
// is resolved by the step logic and then lands in the result register. The walk
// level is updated as each item leaves the input register, so items chain back
// to back. A stalled result holds one more item in the input register; in_ready
// drops only when both are full. arst_n clears the walk state, the config
// registers and all valid flags, not the data registers. cfg_ready is always high.
module ept_leaf_entry_walker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [elew_pkg::GA_W-1:0]       guest_address,
	input  logic [elew_pkg::DATA_W-1:0]     read_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [elew_pkg::ADDR_W-1:0]     address,
	output logic [2:0]                      outcome,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [elew_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [elew_pkg::ADDR_W-1:0]     cfg_data
);
	import elew_pkg::*;

	logic                  valid_s1;
	logic                  opcode_s1;
	gaddr_t                ga_s1;
	logic [DATA_W-1:0]     data_s1;

	level_t                level_q;
	gaddr_t                saved_ga_q;
	addr_t                 last_addr_q;
	addr_t                 root_q;
	logic [PABITS_W-1:0]   pa_bits_q;
	addr_t                 enc_q;

	logic                  out_valid_q;
	kind_t                 kind_q;
	addr_t                 address_q;
	outcome_t              outcome_q;

	step_t                 step;
	logic                  advance;

	elew_step u_step (
		.opcode        (opcode_s1),
		.guest_address (ga_s1),
		.read_data     (data_s1),
		.level         (level_q),
		.saved_ga      (saved_ga_q),
		.last_addr     (last_addr_q),
		.root_addr     (root_q),
		.pa_bits       (pa_bits_q),
		.enc_mask      (enc_q),
		.step          (step)
	);

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign address   = address_q;
	assign outcome   = outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q    <= '0;
			pa_bits_q <= PABITS_RST;
			enc_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROOT:   root_q    <= cfg_data;
				CFG_PABITS: pa_bits_q <= cfg_data[PABITS_W-1:0];
				CFG_ENC:    enc_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1 <= opcode;
			ga_s1     <= guest_address;
			data_s1   <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LVL_IDLE;
			saved_ga_q  <= '0;
			last_addr_q <= '0;
		end else if (advance) begin
			level_q <= step.next_level;
			if (step.save_ga)
				saved_ga_q <= ga_s1;
			if (step.load_last)
				last_addr_q <= step.address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= step.emit;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			kind_q    <= step.kind;
			address_q <= step.address;
			outcome_q <= step.outcome;
		end
	end

	// a pending read request means a walk is in flight
	a_read_implies_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_READ) |-> (level_q != LVL_IDLE))
		else $error("read request pending with walker idle");

	// a pending final result means the walk has ended
	a_result_implies_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_RESULT) |-> (level_q == LVL_IDLE))
		else $error("final result pending with walk still active");

	a_read_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_READ) |-> (outcome_q == OUT_LEAF_4K))
		else $error("read request carries a nonzero outcome");

	a_absent_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (outcome_q == OUT_ABSENT_L4 || outcome_q == OUT_ABSENT_L3 ||
		 outcome_q == OUT_ABSENT_L2 || outcome_q == OUT_HUGE_1G)) |-> (address_q == '0))
		else $error("absent or 1GB result carries an address");

	// stall only when both the input stage and the result register are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled with room available");

endmodule
